@@ rtl/her2_pkg.sv @@
// ----------------------------------------------------------------------------
// her2_pkg
// Shared widths, codes, types and fixed-point helpers of the Hermitian
// rank-2 update block.
// ----------------------------------------------------------------------------
package her2_pkg;

    localparam int ORDER_W   = 6;
    localparam int VEC_DEPTH = 64;
    localparam int COMP_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * COMP_W;
    localparam int RND_W     = PROD_W - FRAC_W;
    localparam int SUM_W     = RND_W + 3;
    localparam int SIZE_W    = 7;
    localparam int CFG_IDX_W = 2;

    // opcodes of an input transaction
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_RE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_IM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE     = 2'd3;

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_W - 1);

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [RND_W-1:0]  rnd_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        comp_t im;
        comp_t re;
    } cplx_t;

    typedef struct packed {
        logic               en;
        logic [ORDER_W-1:0] addr;
        cplx_t              data;
    } vec_wr_t;

    typedef struct packed {
        comp_t val;
        logic  clip;
    } sat_t;

    // full-width signed product
    function automatic prod_t cmul(input comp_t a, input comp_t b);
        prod_t wa;
        prod_t wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    // round to nearest, ties up, then drop the fraction bits
    function automatic rnd_t round_prod(input prod_t p);
        prod_t s;
        s = p + RND_HALF;
        return s[PROD_W-1:FRAC_W];
    endfunction

    // clip a wide sum to one component
    function automatic sat_t sat_comp(input sum_t v);
        sat_t r;
        if (v[SUM_W-1:COMP_W-1] == '0 || v[SUM_W-1:COMP_W-1] == '1)
        begin
            r.val  = v[COMP_W-1:0];
            r.clip = 1'b0;
        end
        else
        begin
            r.val  = v[SUM_W-1] ? {1'b1, {(COMP_W-1){1'b0}}} : {1'b0, {(COMP_W-1){1'b1}}};
            r.clip = 1'b1;
        end
        return r;
    endfunction

endpackage

@@ rtl/her2_if.sv @@
// ----------------------------------------------------------------------------
// her2_if
// Valid/ready channels of the Hermitian rank-2 update block.
// ----------------------------------------------------------------------------
interface her2_in_if;
    import her2_pkg::*;

    logic               valid;
    logic               ready;
    logic               opcode;
    logic [ORDER_W-1:0] row_index;
    logic [ORDER_W-1:0] col_index;
    comp_t              x_real;
    comp_t              x_imag;
    comp_t              y_real;
    comp_t              y_imag;
    comp_t              elem_real;
    comp_t              elem_imag;

    modport source (output valid, opcode, row_index, col_index, x_real, x_imag,
                    y_real, y_imag, elem_real, elem_imag, input ready);
    modport sink   (input valid, opcode, row_index, col_index, x_real, x_imag,
                    y_real, y_imag, elem_real, elem_imag, output ready);
endinterface

interface her2_out_if;
    import her2_pkg::*;

    logic               valid;
    logic               ready;
    logic [ORDER_W-1:0] out_row;
    logic [ORDER_W-1:0] out_col;
    comp_t              new_real;
    comp_t              new_imag;
    logic               saturated;

    modport source (output valid, out_row, out_col, new_real, new_imag, saturated,
                    input ready);
    modport sink   (input valid, out_row, out_col, new_real, new_imag, saturated,
                    output ready);
endinterface

@@ rtl/her2_vec_store.sv @@
// ----------------------------------------------------------------------------
// her2_vec_store
// Complex vector store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module her2_vec_store
(
    input  logic                         clk,
    input  her2_pkg::vec_wr_t            wr,
    input  logic                         rd_en,
    input  logic [her2_pkg::ORDER_W-1:0] raddr_a,
    input  logic [her2_pkg::ORDER_W-1:0] raddr_b,
    output her2_pkg::cplx_t              rdata_a,
    output her2_pkg::cplx_t              rdata_b
);
    import her2_pkg::*;

    cplx_t mem [VEC_DEPTH];
    cplx_t rdata_a_reg;
    cplx_t rdata_b_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read ports, held while the pipeline stalls
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ rtl/hermitian_rank2_update.sv @@
// An update transaction passes through five register stages: store read, alpha
// products, temp sums, row products, final sum and output register.
// Throughput: one transaction per cycle; all stages advance together whenever
// the output register is empty or being taken. Loads produce no result.
// Reset clears valid bits and config (alpha 0, upper mode, n 0); stores are not cleared.
// ----------------------------------------------------------------------------
// hermitian_rank2_update
// Streams matrix elements through A += alpha*x*y^H + conj(alpha)*y*x^H on
// one triangle in signed fixed point with saturation.
// ----------------------------------------------------------------------------
module hermitian_rank2_update
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [her2_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [her2_pkg::COMP_W-1:0]    cfg_wdata,
    her2_in_if.sink                        items,
    her2_out_if.source                     results
);
    import her2_pkg::*;

    // configuration
    comp_t             alpha_re_reg;
    comp_t             alpha_im_reg;
    logic              upper_reg;
    logic [SIZE_W-1:0] size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_re_reg <= '0;
            alpha_im_reg <= '0;
            upper_reg    <= 1'b1;
            size_reg     <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                REG_ALPHA_RE: alpha_re_reg <= cfg_wdata;
                REG_ALPHA_IM: alpha_im_reg <= cfg_wdata;
                REG_UPPER:    upper_reg    <= cfg_wdata[0];
                REG_SIZE:     size_reg     <= cfg_wdata[SIZE_W-1:0];
                default:      ;
            endcase
        end
    end

    // pipeline advance and input handshake
    logic out_valid_reg;
    logic adv;
    logic accept;

    assign adv         = !out_valid_reg || results.ready;
    assign items.ready = adv;
    assign accept      = items.valid && adv;

    // vector stores: port a reads the column entry, port b the row entry
    vec_wr_t x_wr;
    vec_wr_t y_wr;
    cplx_t   xc;
    cplx_t   xr;
    cplx_t   yc;
    cplx_t   yr;

    assign x_wr.en      = accept && (items.opcode == OP_LOAD);
    assign x_wr.addr    = items.row_index;
    assign x_wr.data.re = items.x_real;
    assign x_wr.data.im = items.x_imag;
    assign y_wr.en      = x_wr.en;
    assign y_wr.addr    = items.row_index;
    assign y_wr.data.re = items.y_real;
    assign y_wr.data.im = items.y_imag;

    her2_vec_store u_x_store
    (
        .clk     (clk),
        .wr      (x_wr),
        .rd_en   (adv),
        .raddr_a (items.col_index),
        .raddr_b (items.row_index),
        .rdata_a (xc),
        .rdata_b (xr)
    );

    her2_vec_store u_y_store
    (
        .clk     (clk),
        .wr      (y_wr),
        .rd_en   (adv),
        .raddr_a (items.col_index),
        .raddr_b (items.row_index),
        .rdata_a (yc),
        .rdata_b (yr)
    );

    // stage 1: element selection, alongside the store read
    logic               sel_next;
    logic               s1_valid_reg;
    logic               s1_sel_reg;
    logic               s1_diag_reg;
    logic [ORDER_W-1:0] s1_row_reg;
    logic [ORDER_W-1:0] s1_col_reg;
    comp_t              s1_er_reg;
    comp_t              s1_ei_reg;

    always_comb
    begin
        sel_next = (alpha_re_reg != '0 || alpha_im_reg != '0)
                && ({1'b0, items.row_index} < size_reg)
                && ({1'b0, items.col_index} < size_reg)
                && ((items.row_index == items.col_index)
                    || (upper_reg ? (items.row_index < items.col_index)
                                  : (items.row_index > items.col_index)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept && (items.opcode == OP_UPDATE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sel_reg  <= sel_next;
            s1_diag_reg <= items.row_index == items.col_index;
            s1_row_reg  <= items.row_index;
            s1_col_reg  <= items.col_index;
            s1_er_reg   <= items.elem_real;
            s1_ei_reg   <= items.elem_imag;
        end
    end

    // stage 2: alpha times column entries
    logic               vec_nz;
    logic               s2_valid_reg;
    logic               s2_act_reg;
    logic               s2_zero_im_reg;
    logic               s2_diag_reg;
    logic [ORDER_W-1:0] s2_row_reg;
    logic [ORDER_W-1:0] s2_col_reg;
    comp_t              s2_er_reg;
    comp_t              s2_ei_reg;
    cplx_t              s2_xr_reg;
    cplx_t              s2_yr_reg;
    prod_t              s2_p_reg [8];

    assign vec_nz = (xc.re != '0) || (xc.im != '0) || (yc.re != '0) || (yc.im != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_act_reg     <= s1_sel_reg && vec_nz;
            s2_zero_im_reg <= s1_sel_reg && s1_diag_reg;
            s2_diag_reg    <= s1_diag_reg;
            s2_row_reg     <= s1_row_reg;
            s2_col_reg     <= s1_col_reg;
            s2_er_reg      <= s1_er_reg;
            s2_ei_reg      <= s1_ei_reg;
            s2_xr_reg      <= xr;
            s2_yr_reg      <= yr;
            s2_p_reg[0]    <= cmul(alpha_re_reg, yc.re);
            s2_p_reg[1]    <= cmul(alpha_im_reg, yc.im);
            s2_p_reg[2]    <= cmul(alpha_im_reg, yc.re);
            s2_p_reg[3]    <= cmul(alpha_re_reg, yc.im);
            s2_p_reg[4]    <= cmul(alpha_re_reg, xc.re);
            s2_p_reg[5]    <= cmul(alpha_im_reg, xc.im);
            s2_p_reg[6]    <= cmul(alpha_re_reg, xc.im);
            s2_p_reg[7]    <= cmul(alpha_im_reg, xc.re);
        end
    end

    // stage 3: temp1 = alpha*conj(y_col), temp2 = conj(alpha*x_col)
    sat_t t1r;
    sat_t t1i;
    sat_t t2r;
    sat_t t2i;

    always_comb
    begin
        t1r = sat_comp(sum_t'(round_prod(s2_p_reg[0])) + sum_t'(round_prod(s2_p_reg[1])));
        t1i = sat_comp(sum_t'(round_prod(s2_p_reg[2])) - sum_t'(round_prod(s2_p_reg[3])));
        t2r = sat_comp(sum_t'(round_prod(s2_p_reg[4])) - sum_t'(round_prod(s2_p_reg[5])));
        t2i = sat_comp(-(sum_t'(round_prod(s2_p_reg[6])) + sum_t'(round_prod(s2_p_reg[7]))));
    end

    logic               s3_valid_reg;
    logic               s3_act_reg;
    logic               s3_zero_im_reg;
    logic               s3_diag_reg;
    logic               s3_clip_reg;
    logic [ORDER_W-1:0] s3_row_reg;
    logic [ORDER_W-1:0] s3_col_reg;
    comp_t              s3_er_reg;
    comp_t              s3_ei_reg;
    cplx_t              s3_xr_reg;
    cplx_t              s3_yr_reg;
    cplx_t              s3_t1_reg;
    cplx_t              s3_t2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_act_reg     <= s2_act_reg;
            s3_zero_im_reg <= s2_zero_im_reg;
            s3_diag_reg    <= s2_diag_reg;
            s3_clip_reg    <= t1r.clip || t1i.clip || t2r.clip || t2i.clip;
            s3_row_reg     <= s2_row_reg;
            s3_col_reg     <= s2_col_reg;
            s3_er_reg      <= s2_er_reg;
            s3_ei_reg      <= s2_ei_reg;
            s3_xr_reg      <= s2_xr_reg;
            s3_yr_reg      <= s2_yr_reg;
            s3_t1_reg.re   <= t1r.val;
            s3_t1_reg.im   <= t1i.val;
            s3_t2_reg.re   <= t2r.val;
            s3_t2_reg.im   <= t2i.val;
        end
    end

    // stage 4: row entries times temps (on the diagonal row entry = column entry)
    logic               s4_valid_reg;
    logic               s4_act_reg;
    logic               s4_zero_im_reg;
    logic               s4_diag_reg;
    logic               s4_clip_reg;
    logic [ORDER_W-1:0] s4_row_reg;
    logic [ORDER_W-1:0] s4_col_reg;
    comp_t              s4_er_reg;
    comp_t              s4_ei_reg;
    prod_t              s4_q_reg [8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_act_reg     <= s3_act_reg;
            s4_zero_im_reg <= s3_zero_im_reg;
            s4_diag_reg    <= s3_diag_reg;
            s4_clip_reg    <= s3_clip_reg;
            s4_row_reg     <= s3_row_reg;
            s4_col_reg     <= s3_col_reg;
            s4_er_reg      <= s3_er_reg;
            s4_ei_reg      <= s3_ei_reg;
            s4_q_reg[0]    <= cmul(s3_xr_reg.re, s3_t1_reg.re);
            s4_q_reg[1]    <= cmul(s3_xr_reg.im, s3_t1_reg.im);
            s4_q_reg[2]    <= cmul(s3_yr_reg.re, s3_t2_reg.re);
            s4_q_reg[3]    <= cmul(s3_yr_reg.im, s3_t2_reg.im);
            s4_q_reg[4]    <= cmul(s3_xr_reg.re, s3_t1_reg.im);
            s4_q_reg[5]    <= cmul(s3_xr_reg.im, s3_t1_reg.re);
            s4_q_reg[6]    <= cmul(s3_yr_reg.re, s3_t2_reg.im);
            s4_q_reg[7]    <= cmul(s3_yr_reg.im, s3_t2_reg.re);
        end
    end

    // stage 5: final sums, special cases, output register
    sat_t  nr;
    sat_t  ni;
    comp_t new_re_next;
    comp_t new_im_next;
    logic  sat_next;

    always_comb
    begin
        nr = sat_comp(sum_t'(s4_er_reg)
                      + sum_t'(round_prod(s4_q_reg[0])) - sum_t'(round_prod(s4_q_reg[1]))
                      + sum_t'(round_prod(s4_q_reg[2])) - sum_t'(round_prod(s4_q_reg[3])));
        ni = sat_comp(sum_t'(s4_ei_reg)
                      + sum_t'(round_prod(s4_q_reg[4])) + sum_t'(round_prod(s4_q_reg[5]))
                      + sum_t'(round_prod(s4_q_reg[6])) + sum_t'(round_prod(s4_q_reg[7])));
        new_re_next = s4_er_reg;
        new_im_next = s4_ei_reg;
        sat_next    = 1'b0;
        if (s4_act_reg)
        begin
            new_re_next = nr.val;
            new_im_next = s4_diag_reg ? '0 : ni.val;
            sat_next    = s4_clip_reg || nr.clip || (!s4_diag_reg && ni.clip);
        end
        else if (s4_zero_im_reg)
        begin
            new_im_next = '0;
        end
    end

    logic [ORDER_W-1:0] out_row_reg;
    logic [ORDER_W-1:0] out_col_reg;
    comp_t              new_re_reg;
    comp_t              new_im_reg;
    logic               sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_row_reg <= s4_row_reg;
            out_col_reg <= s4_col_reg;
            new_re_reg  <= new_re_next;
            new_im_reg  <= new_im_next;
            sat_reg     <= sat_next;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.out_row   = out_row_reg;
    assign results.out_col   = out_col_reg;
    assign results.new_real  = new_re_reg;
    assign results.new_imag  = new_im_reg;
    assign results.saturated = sat_reg;

endmodule
